/* design/gvfr_pkg.sv */
`default_nettype none
package gvfr_pkg;

   localparam int MAX_COLS = 64;
   localparam int MAX_ROWS = 64;

   localparam int DEPTH  = MAX_COLS * MAX_ROWS;
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int COL_W  = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
   localparam int ROW_W  = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
   localparam int IDX_W  = 9;

   localparam int WORD_W = 32;
   localparam int SIZE_W = 7;
   localparam int CS_W   = 8;
   localparam int POS_W  = 20;
   localparam int RAD_W  = 18;
   localparam int STR_W  = 16;
   localparam int FRC_W  = 16;
   localparam int CNT_W  = 13;
   localparam int CSR_W  = 2;

   localparam int CX_W   = 20;
   localparam int DX_W   = 22;
   localparam int SQ_W   = 44;
   localparam int R2_W   = 36;
   localparam int RQ_W   = 22;
   localparam int P1_W   = 34;
   localparam int PR_W   = 56;
   localparam int REM_W  = 44;
   localparam int Q_W    = 26;
   localparam int STEP_W = 5;

   localparam logic [CSR_W-1:0] CSR_CELL_SIZE = 2'd0;
   localparam logic [CSR_W-1:0] CSR_GRID_COLS = 2'd1;
   localparam logic [CSR_W-1:0] CSR_GRID_ROWS = 2'd2;

   localparam logic OP_REPEL = 1'b0;
   localparam logic OP_QUERY = 1'b1;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DIFF,
      ST_SQUARE,
      ST_TEST,
      ST_SQRT,
      ST_MUL1,
      ST_MUL2,
      ST_DIV,
      ST_WRITE,
      ST_QADDR,
      ST_RESP
   } state_type;

endpackage
`default_nettype wire

/* design/gvfr_ram.sv */
`default_nettype none
module gvfr_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 4096
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

/* design/grid_vector_field_repulsion_top.sv */
// channel | ports                                          | dir
// req     | req_valid req_ready req_type req_pos_x/y ...   | in
// rsp     | rsp_valid rsp_ready rsp_force_x/y cells_changed| out
// csr     | csr_we csr_addr csr_wdata                      | in
// After reset the field memory is cleared, one entry a cycle, all 4096 entries, req_ready low.
// Query: after accept, a 26-step divider on the position, one memory read and a result
// state; rsp_valid and req_ready rise in the same cycle.
// Repulsion: each grid cell passes DIFF, SQUARE and TEST; a cell inside adds 22 square-root
// steps, the multiply states MUL1 and MUL2, 26 divider steps and a write; a result state at the end.
// One word in work at a time; the result register frees the input side while rsp stalls.
`default_nettype none
module grid_vector_field_repulsion_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic                                req_type,
   input  wire logic signed [gvfr_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic signed [gvfr_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic        [gvfr_pkg::RAD_W-1:0]   req_radius,
   input  wire logic signed [gvfr_pkg::STR_W-1:0]   req_strength,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic signed      [gvfr_pkg::FRC_W-1:0]   rsp_force_x,
   output logic signed      [gvfr_pkg::FRC_W-1:0]   rsp_force_y,
   output logic             [gvfr_pkg::CNT_W-1:0]   rsp_cells_changed,
   input  wire logic                                csr_we,
   input  wire logic        [gvfr_pkg::CSR_W-1:0]   csr_addr,
   input  wire logic        [gvfr_pkg::CS_W-1:0]    csr_wdata
);

   localparam int AW = gvfr_pkg::ADDR_W;

   gvfr_pkg::state_type state_ff, state_in;

   logic [gvfr_pkg::CS_W-1:0]   cell_size_ff;
   logic [gvfr_pkg::SIZE_W-1:0] grid_cols_ff, grid_rows_ff;

   logic                               op_ff;
   logic signed [gvfr_pkg::POS_W-1:0]  px_ff, py_ff;
   logic [gvfr_pkg::RAD_W-1:0]         rad_ff;
   logic signed [gvfr_pkg::STR_W-1:0]  str_ff;
   logic [gvfr_pkg::R2_W-1:0]          r2_ff;

   logic [gvfr_pkg::CX_W-1:0]  cx_ff, cy_ff;
   logic [gvfr_pkg::COL_W-1:0] col_ff;
   logic [gvfr_pkg::ROW_W-1:0] row_ff;
   logic signed [gvfr_pkg::DX_W-1:0] dx_ff, dy_ff;
   logic [gvfr_pkg::SQ_W-1:0]  sqx_ff, sqy_ff;
   logic [gvfr_pkg::SQ_W-1:0]  n_ff, res_ff, bit_ff;
   logic [gvfr_pkg::P1_W-1:0]  p1x_ff, p1y_ff;
   logic [gvfr_pkg::RQ_W-1:0]  w_ff;
   logic                       negx_ff, negy_ff;
   logic [gvfr_pkg::REM_W-1:0] remx_ff, remy_ff, dsh_ff;
   logic [gvfr_pkg::Q_W-1:0]   qx_ff, qy_ff;
   logic [gvfr_pkg::STEP_W-1:0] cnt_ff;
   logic [gvfr_pkg::CNT_W-1:0] count_ff;
   logic [AW-1:0]              clr_ff;

   logic                                rsp_valid_ff;
   logic signed [gvfr_pkg::FRC_W-1:0]   force_x_ff, force_y_ff;
   logic [gvfr_pkg::CNT_W-1:0]          cells_ff;

   logic [gvfr_pkg::CS_W-1:0]   eff_cs;
   logic [gvfr_pkg::SIZE_W-1:0] eff_cols, eff_rows, last_col, last_row;
   logic [gvfr_pkg::CX_W-1:0]   step16;
   logic                        accept, cell_last, row_last, in_radius, sqrt_ge, out_free;
   logic signed [gvfr_pkg::DX_W-1:0] dx_calc, dy_calc;
   logic [gvfr_pkg::SQ_W:0]     d2, trial;
   logic [gvfr_pkg::RAD_W-1:0]  adx, ady;
   logic [gvfr_pkg::STR_W-1:0]  astr;
   logic [gvfr_pkg::PR_W-1:0]   prodx, prody;
   logic signed [gvfr_pkg::FRC_W-1:0] satx, saty;
   logic [gvfr_pkg::COL_W-1:0]  qcol;
   logic [gvfr_pkg::ROW_W-1:0]  qrow;

   logic                ram_we, ram_re;
   logic [AW-1:0]       ram_waddr, ram_raddr;
   logic [gvfr_pkg::WORD_W-1:0] ram_wdata, ram_rdata;

   function automatic logic signed [gvfr_pkg::FRC_W-1:0] sat_q(
      input logic [gvfr_pkg::Q_W-1:0] q, input logic neg);
      logic signed [gvfr_pkg::FRC_W-1:0] r;
      if (neg) begin
         if (q > gvfr_pkg::Q_W'(32768)) r = 16'sh8000;
         else r = gvfr_pkg::FRC_W'(-q);
      end else begin
         if (q > gvfr_pkg::Q_W'(32767)) r = 16'sh7fff;
         else r = gvfr_pkg::FRC_W'(q);
      end
      return r;
   endfunction

   // effective configuration
   always_comb begin
      eff_cs = (cell_size_ff == '0) ? gvfr_pkg::CS_W'(1) : cell_size_ff;
      if (grid_cols_ff == '0) eff_cols = gvfr_pkg::SIZE_W'(1);
      else if (int'(grid_cols_ff) > gvfr_pkg::MAX_COLS)
         eff_cols = gvfr_pkg::SIZE_W'(gvfr_pkg::MAX_COLS);
      else eff_cols = grid_cols_ff;
      if (grid_rows_ff == '0) eff_rows = gvfr_pkg::SIZE_W'(1);
      else if (int'(grid_rows_ff) > gvfr_pkg::MAX_ROWS)
         eff_rows = gvfr_pkg::SIZE_W'(gvfr_pkg::MAX_ROWS);
      else eff_rows = grid_rows_ff;
      last_col = eff_cols - gvfr_pkg::SIZE_W'(1);
      last_row = eff_rows - gvfr_pkg::SIZE_W'(1);
      step16   = gvfr_pkg::CX_W'({eff_cs, 4'b0000});
   end

   always_comb begin
      accept    = req_valid && req_ready;
      out_free  = !rsp_valid_ff || rsp_ready;
      row_last  = gvfr_pkg::IDX_W'(row_ff) == gvfr_pkg::IDX_W'(last_row);
      cell_last = row_last && (gvfr_pkg::IDX_W'(col_ff) == gvfr_pkg::IDX_W'(last_col));
      dx_calc   = $signed({2'b00, cx_ff}) - $signed({{2{px_ff[gvfr_pkg::POS_W-1]}}, px_ff});
      dy_calc   = $signed({2'b00, cy_ff}) - $signed({{2{py_ff[gvfr_pkg::POS_W-1]}}, py_ff});
      d2        = {1'b0, sqx_ff} + {1'b0, sqy_ff};
      in_radius = d2 < (gvfr_pkg::SQ_W + 1)'(r2_ff);
      trial     = {1'b0, res_ff} + {1'b0, bit_ff};
      sqrt_ge   = {1'b0, n_ff} >= trial;
      adx       = gvfr_pkg::RAD_W'(dx_ff[gvfr_pkg::DX_W-1] ? -dx_ff : dx_ff);
      ady       = gvfr_pkg::RAD_W'(dy_ff[gvfr_pkg::DX_W-1] ? -dy_ff : dy_ff);
      astr      = gvfr_pkg::STR_W'(str_ff[gvfr_pkg::STR_W-1] ? -str_ff : str_ff);
      prodx     = gvfr_pkg::PR_W'(p1x_ff) * gvfr_pkg::PR_W'(w_ff);
      prody     = gvfr_pkg::PR_W'(p1y_ff) * gvfr_pkg::PR_W'(w_ff);
      satx      = sat_q(qx_ff, negx_ff);
      saty      = sat_q(qy_ff, negy_ff);
      qcol      = (qx_ff > gvfr_pkg::Q_W'(last_col)) ? gvfr_pkg::COL_W'(last_col)
                                                      : gvfr_pkg::COL_W'(qx_ff);
      qrow      = (qy_ff > gvfr_pkg::Q_W'(last_row)) ? gvfr_pkg::ROW_W'(last_row)
                                                      : gvfr_pkg::ROW_W'(qy_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         gvfr_pkg::ST_CLEAR:  if (clr_ff == AW'(gvfr_pkg::DEPTH - 1)) state_in = gvfr_pkg::ST_IDLE;
         gvfr_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_type == gvfr_pkg::OP_QUERY) ? gvfr_pkg::ST_DIV : gvfr_pkg::ST_DIFF;
            end
         end
         gvfr_pkg::ST_DIFF:   state_in = gvfr_pkg::ST_SQUARE;
         gvfr_pkg::ST_SQUARE: state_in = gvfr_pkg::ST_TEST;
         gvfr_pkg::ST_TEST: begin
            if (in_radius) state_in = gvfr_pkg::ST_SQRT;
            else if (cell_last) state_in = gvfr_pkg::ST_RESP;
            else state_in = gvfr_pkg::ST_DIFF;
         end
         gvfr_pkg::ST_SQRT:   if (bit_ff[0]) state_in = gvfr_pkg::ST_MUL1;
         gvfr_pkg::ST_MUL1:   state_in = gvfr_pkg::ST_MUL2;
         gvfr_pkg::ST_MUL2:   state_in = gvfr_pkg::ST_DIV;
         gvfr_pkg::ST_DIV: begin
            if (cnt_ff == '0) begin
               state_in = (op_ff == gvfr_pkg::OP_QUERY) ? gvfr_pkg::ST_QADDR : gvfr_pkg::ST_WRITE;
            end
         end
         gvfr_pkg::ST_WRITE:  state_in = cell_last ? gvfr_pkg::ST_RESP : gvfr_pkg::ST_DIFF;
         gvfr_pkg::ST_QADDR:  state_in = gvfr_pkg::ST_RESP;
         gvfr_pkg::ST_RESP:   if (out_free) state_in = gvfr_pkg::ST_IDLE;
         default:             state_in = gvfr_pkg::ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_ready = 1'b0;
      ram_we    = 1'b0;
      ram_waddr = AW'(col_ff) * AW'(gvfr_pkg::MAX_ROWS) + AW'(row_ff);
      ram_wdata = {saty, satx};
      ram_re    = 1'b0;
      ram_raddr = AW'(qcol) * AW'(gvfr_pkg::MAX_ROWS) + AW'(qrow);
      unique case (state_ff)
         gvfr_pkg::ST_CLEAR: begin
            ram_we    = 1'b1;
            ram_waddr = clr_ff;
            ram_wdata = '0;
         end
         gvfr_pkg::ST_IDLE:  req_ready = 1'b1;
         gvfr_pkg::ST_WRITE: ram_we = 1'b1;
         gvfr_pkg::ST_QADDR: ram_re = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= gvfr_pkg::ST_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         cell_size_ff <= gvfr_pkg::CS_W'(10);
         grid_cols_ff <= gvfr_pkg::SIZE_W'(64);
         grid_rows_ff <= gvfr_pkg::SIZE_W'(64);
      end else begin
         state_ff <= state_in;
         if (state_ff == gvfr_pkg::ST_CLEAR) clr_ff <= clr_ff + AW'(1);
         if (csr_we) begin
            unique case (csr_addr)
               gvfr_pkg::CSR_CELL_SIZE: cell_size_ff <= csr_wdata;
               gvfr_pkg::CSR_GRID_COLS: grid_cols_ff <= csr_wdata[gvfr_pkg::SIZE_W-1:0];
               gvfr_pkg::CSR_GRID_ROWS: grid_rows_ff <= csr_wdata[gvfr_pkg::SIZE_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == gvfr_pkg::ST_RESP && out_free) rsp_valid_ff <= 1'b1;
         else if (rsp_ready) rsp_valid_ff <= 1'b0;
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      case (state_ff)
         gvfr_pkg::ST_IDLE: begin
            if (accept) begin
               op_ff    <= req_type;
               px_ff    <= req_pos_x;
               py_ff    <= req_pos_y;
               rad_ff   <= req_radius;
               str_ff   <= req_strength;
               r2_ff    <= gvfr_pkg::R2_W'(req_radius) * gvfr_pkg::R2_W'(req_radius);
               col_ff   <= '0;
               row_ff   <= '0;
               cx_ff    <= '0;
               cy_ff    <= '0;
               count_ff <= '0;
               remx_ff  <= req_pos_x[gvfr_pkg::POS_W-1] ? '0
                           : gvfr_pkg::REM_W'(req_pos_x[gvfr_pkg::POS_W-2:4]);
               remy_ff  <= req_pos_y[gvfr_pkg::POS_W-1] ? '0
                           : gvfr_pkg::REM_W'(req_pos_y[gvfr_pkg::POS_W-2:4]);
               dsh_ff   <= gvfr_pkg::REM_W'(eff_cs) << (gvfr_pkg::Q_W - 1);
               qx_ff    <= '0;
               qy_ff    <= '0;
               cnt_ff   <= gvfr_pkg::STEP_W'(gvfr_pkg::Q_W - 1);
            end
         end
         gvfr_pkg::ST_DIFF: begin
            dx_ff <= dx_calc;
            dy_ff <= dy_calc;
         end
         gvfr_pkg::ST_SQUARE: begin
            sqx_ff <= gvfr_pkg::SQ_W'(dx_ff * dx_ff);
            sqy_ff <= gvfr_pkg::SQ_W'(dy_ff * dy_ff);
         end
         gvfr_pkg::ST_TEST: begin
            n_ff   <= {d2[gvfr_pkg::R2_W-1:0], 8'h00};
            res_ff <= '0;
            bit_ff <= gvfr_pkg::SQ_W'(1) << (gvfr_pkg::SQ_W - 2);
         end
         gvfr_pkg::ST_SQRT: begin
            if (sqrt_ge) begin
               n_ff   <= n_ff - trial[gvfr_pkg::SQ_W-1:0];
               res_ff <= (res_ff >> 1) + bit_ff;
            end else begin
               res_ff <= res_ff >> 1;
            end
            bit_ff <= bit_ff >> 2;
         end
         gvfr_pkg::ST_MUL1: begin
            p1x_ff  <= gvfr_pkg::P1_W'(adx) * gvfr_pkg::P1_W'(astr);
            p1y_ff  <= gvfr_pkg::P1_W'(ady) * gvfr_pkg::P1_W'(astr);
            w_ff    <= {rad_ff, 4'b0000} - res_ff[gvfr_pkg::RQ_W-1:0];
            negx_ff <= dx_ff[gvfr_pkg::DX_W-1] ^ str_ff[gvfr_pkg::STR_W-1];
            negy_ff <= dy_ff[gvfr_pkg::DX_W-1] ^ str_ff[gvfr_pkg::STR_W-1];
         end
         gvfr_pkg::ST_MUL2: begin
            remx_ff <= prodx[gvfr_pkg::PR_W-1:12];
            remy_ff <= prody[gvfr_pkg::PR_W-1:12];
            dsh_ff  <= gvfr_pkg::REM_W'(rad_ff) << (gvfr_pkg::Q_W - 1);
            qx_ff   <= '0;
            qy_ff   <= '0;
            cnt_ff  <= gvfr_pkg::STEP_W'(gvfr_pkg::Q_W - 1);
         end
         gvfr_pkg::ST_DIV: begin
            if (remx_ff >= dsh_ff) begin
               remx_ff <= remx_ff - dsh_ff;
               qx_ff   <= {qx_ff[gvfr_pkg::Q_W-2:0], 1'b1};
            end else begin
               qx_ff   <= {qx_ff[gvfr_pkg::Q_W-2:0], 1'b0};
            end
            if (remy_ff >= dsh_ff) begin
               remy_ff <= remy_ff - dsh_ff;
               qy_ff   <= {qy_ff[gvfr_pkg::Q_W-2:0], 1'b1};
            end else begin
               qy_ff   <= {qy_ff[gvfr_pkg::Q_W-2:0], 1'b0};
            end
            dsh_ff <= dsh_ff >> 1;
            cnt_ff <= cnt_ff - gvfr_pkg::STEP_W'(1);
         end
         default: ;
      endcase

      if (state_ff == gvfr_pkg::ST_WRITE) count_ff <= count_ff + gvfr_pkg::CNT_W'(1);

      if ((state_ff == gvfr_pkg::ST_WRITE) || (state_ff == gvfr_pkg::ST_TEST && !in_radius)) begin
         if (row_last) begin
            row_ff <= '0;
            cy_ff  <= '0;
            col_ff <= col_ff + gvfr_pkg::COL_W'(1);
            cx_ff  <= cx_ff + step16;
         end else begin
            row_ff <= row_ff + gvfr_pkg::ROW_W'(1);
            cy_ff  <= cy_ff + step16;
         end
      end

      if (state_ff == gvfr_pkg::ST_RESP && out_free) begin
         if (op_ff == gvfr_pkg::OP_QUERY) begin
            force_x_ff <= ram_rdata[gvfr_pkg::FRC_W-1:0];
            force_y_ff <= ram_rdata[gvfr_pkg::WORD_W-1:gvfr_pkg::FRC_W];
            cells_ff   <= '0;
         end else begin
            force_x_ff <= '0;
            force_y_ff <= '0;
            cells_ff   <= count_ff;
         end
      end
   end

   gvfr_ram #(
      .WIDTH(gvfr_pkg::WORD_W),
      .DEPTH(gvfr_pkg::DEPTH)
   ) u_field (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_force_x       = force_x_ff;
   assign rsp_force_y       = force_y_ff;
   assign rsp_cells_changed = cells_ff;

endmodule
`default_nettype wire

/* design/gvfr_checker.sv */
`default_nettype none
module gvfr_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_valid,
   input wire logic                              req_ready,
   input wire logic                              rsp_valid,
   input wire logic                              rsp_ready,
   input wire logic [gvfr_pkg::FRC_W-1:0]        rsp_force_x,
   input wire logic [gvfr_pkg::FRC_W-1:0]        rsp_force_y,
   input wire logic [gvfr_pkg::CNT_W-1:0]        rsp_cells_changed
);

   // memory clear keeps the input side closed after reset
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready) else $error("req_ready high right after reset");

   // one word in work at a time
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("second word taken while busy");

   // a nonzero vector only comes from a query, which reports no count
   a_query_no_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_force_x != '0 || rsp_force_y != '0) |-> rsp_cells_changed == '0)
      else $error("vector and count both nonzero");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_force_x)
         && $stable(rsp_force_y) && $stable(rsp_cells_changed))
      else $error("stalled result word changed");

endmodule

bind grid_vector_field_repulsion_top gvfr_checker u_gvfr_checker (.*);
`default_nettype wire

/* sim/gvfr_checker.sv */
`timescale 1ns / 1ps
`default_nettype none
module gvfr_scoreboard (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   input  wire logic                                req_ready,
   input  wire logic                                req_type,
   input  wire logic signed [gvfr_pkg::POS_W-1:0]   req_pos_x,
   input  wire logic signed [gvfr_pkg::POS_W-1:0]   req_pos_y,
   input  wire logic        [gvfr_pkg::RAD_W-1:0]   req_radius,
   input  wire logic signed [gvfr_pkg::STR_W-1:0]   req_strength,
   input  wire logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   input  wire logic signed [gvfr_pkg::FRC_W-1:0]   rsp_force_x,
   input  wire logic signed [gvfr_pkg::FRC_W-1:0]   rsp_force_y,
   input  wire logic        [gvfr_pkg::CNT_W-1:0]   rsp_cells_changed,
   input  wire logic                                csr_we,
   input  wire logic        [gvfr_pkg::CSR_W-1:0]   csr_addr,
   input  wire logic        [gvfr_pkg::CS_W-1:0]    csr_wdata,
   output int                                       fail_count,
   output int                                       words_pending
);
   import gvfr_pkg::*;

   localparam int FIFO_DEPTH = 16;

   typedef struct {
      logic signed [FRC_W-1:0] fx;
      logic signed [FRC_W-1:0] fy;
      logic [CNT_W-1:0]        cnt;
   } force_word_type;

   force_word_type    expected_forces[FIFO_DEPTH];
   int                wr_ptr;
   int                rd_ptr;
   logic [WORD_W-1:0] field_model[DEPTH];
   logic [CS_W-1:0]   cell_size_q;
   logic [SIZE_W-1:0] cols_q;
   logic [SIZE_W-1:0] rows_q;

   assign words_pending = wr_ptr - rd_ptr;

   function automatic longint unsigned int_sqrt(longint unsigned n);
      longint unsigned res;
      longint unsigned b;
      res = 0;
      b = 64'd1 << 62;
      while (b > n) b = b >> 2;
      while (b != 0) begin
         if (n >= res + b) begin
            n = n - (res + b);
            res = (res >> 1) + b;
         end else begin
            res = res >> 1;
         end
         b = b >> 2;
      end
      return res;
   endfunction

   function automatic logic [15:0] clip16(longint v);
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return v[15:0];
   endfunction

   function automatic int grid_dim(logic [SIZE_W-1:0] v, int maxv);
      if (v == 0) return 1;
      return (v > maxv) ? maxv : int'(v);
   endfunction

   function automatic force_word_type predict_force(logic op, longint px, longint py,
                                                    longint rad, longint str);
      force_word_type w;
      longint cs, dx, dy, rq, dq, k, dv, step, xi, yi;
      longint unsigned d2, r2;
      int cols, rows, count;
      logic [15:0] fx, fy;
      logic [WORD_W-1:0] v;
      cs = (cell_size_q == 0) ? 1 : longint'(cell_size_q);
      cols = grid_dim(cols_q, MAX_COLS);
      rows = grid_dim(rows_q, MAX_ROWS);
      w.fx = 0;
      w.fy = 0;
      w.cnt = 0;
      if (op == OP_REPEL) begin
         count = 0;
         r2 = rad * rad;
         rq = rad << 4;
         for (int c = 0; c < cols; c++) begin
            for (int r = 0; r < rows; r++) begin
               dx = longint'(c) * cs * 16 - px;
               dy = longint'(r) * cs * 16 - py;
               d2 = dx * dx + dy * dy;
               if (d2 < r2) begin
                  dq = int_sqrt(d2 << 8);
                  k = (rq - dq) * str;
                  dv = rq * 256;
                  fx = clip16((dx * k) / dv);
                  fy = clip16((dy * k) / dv);
                  field_model[c * MAX_ROWS + r] = {fy, fx};
                  count++;
               end
            end
         end
         w.cnt = count[CNT_W-1:0];
      end else begin
         step = cs * 16;
         xi = px / step;
         yi = py / step;
         if (xi < 0) xi = 0;
         if (xi > cols - 1) xi = cols - 1;
         if (yi < 0) yi = 0;
         if (yi > rows - 1) yi = rows - 1;
         v = field_model[xi * MAX_ROWS + yi];
         w.fx = v[15:0];
         w.fy = v[31:16];
      end
      return w;
   endfunction

   always @(posedge clock) begin
      force_word_type want;
      int errs;
      errs = 0;
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) field_model[i] = '0;
         cell_size_q <= 8'd10;
         cols_q <= 7'd64;
         rows_q <= 7'd64;
         wr_ptr <= 0;
         rd_ptr <= 0;
         fail_count <= 0;
      end else begin
         if (csr_we) begin
            case (csr_addr)
               CSR_CELL_SIZE: cell_size_q <= csr_wdata;
               CSR_GRID_COLS: cols_q <= csr_wdata[SIZE_W-1:0];
               CSR_GRID_ROWS: rows_q <= csr_wdata[SIZE_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            expected_forces[wr_ptr % FIFO_DEPTH] = predict_force(req_type,
               longint'(req_pos_x), longint'(req_pos_y), longint'(req_radius),
               longint'(req_strength));
            wr_ptr <= wr_ptr + 1;
         end
         if (rsp_valid && rsp_ready) begin
            if (wr_ptr == rd_ptr) begin
               $error("unexpected rsp word");
               errs++;
            end else begin
               want = expected_forces[rd_ptr % FIFO_DEPTH];
               rd_ptr <= rd_ptr + 1;
               if (rsp_force_x !== want.fx) begin
                  $error("force_x exp %0d got %0d", want.fx, rsp_force_x);
                  errs++;
               end
               if (rsp_force_y !== want.fy) begin
                  $error("force_y exp %0d got %0d", want.fy, rsp_force_y);
                  errs++;
               end
               if (rsp_cells_changed !== want.cnt) begin
                  $error("cells_changed exp %0d got %0d", want.cnt, rsp_cells_changed);
                  errs++;
               end
            end
         end
         fail_count <= fail_count + errs;
      end
   end
endmodule
`default_nettype wire

/* sim/testbench.sv */
`timescale 1ns / 1ps
`default_nettype none
module testbench;
   import gvfr_pkg::*;

   localparam longint LIMIT = 3000000;

   logic clock, reset;
   logic req_valid, req_ready, req_type;
   logic signed [POS_W-1:0] req_pos_x, req_pos_y;
   logic [RAD_W-1:0] req_radius;
   logic signed [STR_W-1:0] req_strength;
   logic rsp_valid, rsp_ready;
   logic signed [FRC_W-1:0] rsp_force_x, rsp_force_y;
   logic [CNT_W-1:0] rsp_cells_changed;
   logic csr_we;
   logic [CSR_W-1:0] csr_addr;
   logic [CS_W-1:0] csr_wdata;
   int fail_count, words_pending;
   bit idle_on;
   longint cycles;
   int cs_now, cols_now, rows_now;

   grid_vector_field_repulsion_top i_dut (.*);
   gvfr_scoreboard i_checker (.*);

   initial begin
      clock = 0;
      forever #5 clock = ~clock;
   end

   initial begin
      rsp_ready = 0;
      forever begin
         @(posedge clock);
         rsp_ready <= (idle_on && $urandom_range(99) < 34) ? 1'b0 : 1'b1;
      end
   end

   initial begin
      cycles = 0;
      forever begin
         @(posedge clock);
         cycles++;
         if (cycles > LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
         end
      end
   end

   task automatic send_word(logic op, logic signed [POS_W-1:0] x, logic signed [POS_W-1:0] y,
                            logic [RAD_W-1:0] rad, logic signed [STR_W-1:0] str);
      bit done;
      while (idle_on && $urandom_range(99) < 34) @(posedge clock);
      req_valid <= 1'b1;
      req_type <= op;
      req_pos_x <= x;
      req_pos_y <= y;
      req_radius <= rad;
      req_strength <= str;
      done = 0;
      while (!done) begin
         @(negedge clock);
         done = req_ready;
         @(posedge clock);
      end
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic write_reg(logic [CSR_W-1:0] a, logic [CS_W-1:0] d);
      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= a;
      csr_wdata <= d;
      @(posedge clock);
      csr_we <= 1'b0;
      if (a == CSR_CELL_SIZE) cs_now = (d == 0) ? 1 : int'(d);
      if (a == CSR_GRID_COLS)
         cols_now = (d[6:0] == 0) ? 1 : (d[6:0] > 64 ? 64 : int'(d[6:0]));
      if (a == CSR_GRID_ROWS)
         rows_now = (d[6:0] == 0) ? 1 : (d[6:0] > 64 ? 64 : int'(d[6:0]));
   endtask

   task automatic random_word();
      int span_x, span_y, mode;
      logic signed [POS_W-1:0] x, y;
      logic [RAD_W-1:0] rad;
      mode = $urandom_range(9);
      span_x = cols_now * cs_now * 16;
      span_y = rows_now * cs_now * 16;
      x = POS_W'($urandom_range(span_x + 64) - 32);
      y = POS_W'($urandom_range(span_y + 64) - 32);
      rad = RAD_W'($urandom_range(cs_now * 16 * 4));
      if (mode == 0) begin
         x = POS_W'($urandom);
         y = POS_W'($urandom);
         rad = RAD_W'($urandom);
      end
      if (mode < 5)
         send_word(OP_REPEL, x, y, rad, STR_W'($urandom));
      else
         send_word(OP_QUERY, x, y, rad, STR_W'($urandom));
   endtask

   initial begin
      idle_on = 1;
      reset = 1;
      req_valid = 0; req_type = 0; req_pos_x = 0; req_pos_y = 0;
      req_radius = 0; req_strength = 0;
      csr_we = 0; csr_addr = 0; csr_wdata = 0;
      cs_now = 10; cols_now = 64; rows_now = 64;
      repeat (8) @(posedge clock);
      reset <= 0;

      // directed: empty store, full-grid sweep, clamped queries
      send_word(OP_QUERY, 20'sd0, 20'sd0, '0, '0);
      send_word(OP_REPEL, 20'sd5000, 20'sd5000, 18'd262143, 16'sd32767);
      send_word(OP_QUERY, -20'sd524288, -20'sd524288, '0, '0);
      send_word(OP_QUERY, 20'sd524287, 20'sd524287, 18'h3FFFF, -16'sd1);
      send_word(OP_QUERY, 20'sd1600, 20'sd3200, '0, '0);
      send_word(OP_REPEL, 20'sd800, 20'sd800, 18'd0, 16'sd256);
      send_word(OP_REPEL, 20'sd800, 20'sd800, 18'd500, -16'sd32768);
      send_word(OP_QUERY, 20'sd790, 20'sd800, '0, '0);
      send_word(OP_QUERY, 20'sd960, 20'sd800, '0, '0);
      write_reg(CSR_CELL_SIZE, 8'd0);
      write_reg(CSR_GRID_COLS, 8'd127);
      write_reg(CSR_GRID_ROWS, 8'd0);
      send_word(OP_REPEL, 20'sd300, 20'sd0, 18'd200, 16'sd1000);
      send_word(OP_QUERY, 20'sd300, 20'sd5000, '0, '0);
      send_word(OP_QUERY, 20'sd330, -20'sd5, '0, '0);
      write_reg(CSR_CELL_SIZE, 8'd255);
      write_reg(CSR_GRID_COLS, 8'd0);
      write_reg(CSR_GRID_ROWS, 8'd255);
      send_word(OP_REPEL, 20'sd0, 20'sd30000, 18'd20000, -16'sd700);
      send_word(OP_QUERY, -20'sd100, 20'sd30000, '0, '0);
      send_word(OP_QUERY, 20'sd0, 20'sd524287, '0, '0);

      for (int ph = 0; ph < 7; ph++) begin
         write_reg(CSR_CELL_SIZE,
                   CS_W'((ph % 3 == 0) ? $urandom_range(255) : $urandom_range(1, 12)));
         write_reg(CSR_GRID_COLS, CS_W'(($urandom_range(1) << 7) | $urandom_range(1, 6)));
         write_reg(CSR_GRID_ROWS, CS_W'($urandom_range(0, 6)));
         idle_on = (ph != 3);
         for (int n = 0; n < 18; n++) random_word();
      end
      idle_on = 1;

      @(posedge clock);
      while (words_pending != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end
endmodule
`default_nettype wire

/* filelist.f */
design/gvfr_pkg.sv
design/gvfr_ram.sv
design/grid_vector_field_repulsion_top.sv
design/gvfr_checker.sv
sim/gvfr_checker.sv
sim/testbench.sv
